### design/vector_distance_engine_core_defines.svh
// assertion macros for the vector distance engine
// used by the datapath module, relies on clk and rst_n in scope
`ifndef VECTOR_DISTANCE_ENGINE_CORE_DEFINES_SVH
`define VECTOR_DISTANCE_ENGINE_CORE_DEFINES_SVH

// same-cycle implication
`define VDE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VDE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/vde_pkg.sv
// shared types and constants of the vector distance engine
// no dependencies
package vde_pkg;

  localparam int VAL_W = 32;

  localparam logic [1:0] METRIC_EUCLID    = 2'd0;
  localparam logic [1:0] METRIC_MANHATTAN = 2'd1;
  localparam logic [1:0] METRIC_COSINE    = 2'd2;
  localparam logic [1:0] METRIC_RESERVED  = 2'd3;

  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  typedef struct packed {
    logic       accept_ok;
    logic       sq_load_sum;
    logic       sq_load_quot;
    logic       sq_step;
    logic       mul_issue;
    logic [2:0] mul_step;
    logic       div_init;
    logic       div_step;
    logic       load_out;
  } vde_cmd_t;

  typedef struct packed {
    logic       last_pending;
    logic [1:0] fin_metric;
    logic       zero_norm;
    logic       d_ge_p;
    logic       out_free;
  } vde_sts_t;

endpackage

### design/vde_ctrl.sv
// controller of the vector distance engine: sequences the finish of a vector
// depends on vde_pkg
module vde_ctrl import vde_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  vde_sts_t sts,
  output vde_cmd_t cmd
);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_FIN      = 8'b0000_0010,
    ST_SQRT     = 8'b0000_0100,
    ST_MUL      = 8'b0000_1000,
    ST_MUL_WAIT = 8'b0001_0000,
    ST_CHK      = 8'b0010_0000,
    ST_DIV      = 8'b0100_0000,
    ST_OUT      = 8'b1000_0000
  } state_t;

  state_t     state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.accept_ok = !sts.last_pending;
        if (sts.last_pending) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cnt_nxt = '0;
        case (sts.fin_metric)
          METRIC_MANHATTAN: state_nxt = ST_OUT;
          METRIC_COSINE:    state_nxt = sts.zero_norm ? ST_OUT : ST_MUL;
          default: begin
            cmd.sq_load_sum = 1'b1;
            state_nxt       = ST_SQRT;
          end
        endcase
      end
      ST_SQRT: begin
        cmd.sq_step = 1'b1;
        cnt_nxt     = cnt_r + 5'd1;
        if (cnt_r == 5'd31) state_nxt = ST_OUT;
      end
      ST_MUL: begin
        cmd.mul_issue = 1'b1;
        cmd.mul_step  = cnt_r[2:0];
        cnt_nxt       = cnt_r + 5'd1;
        if (cnt_r[2:0] == 3'd7) state_nxt = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: state_nxt = ST_CHK;
      ST_CHK: begin
        cnt_nxt = '0;
        if (sts.d_ge_p) begin
          state_nxt = ST_OUT;
        end else begin
          cmd.div_init = 1'b1;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          cmd.sq_load_quot = 1'b1;
          state_nxt        = ST_SQRT;
        end
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

### design/vde_dp.sv
// datapath of the vector distance engine: accumulators, multiplier,
// divider, square root and result register; depends on vde_pkg and the defines header
`include "vector_distance_engine_core_defines.svh"
module vde_dp import vde_pkg::*; #(
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  vde_cmd_t    cmd,
  output vde_sts_t    sts,
  input  logic [1:0]  cfg_data,
  input  logic        cfg_we,
  input  logic        in_valid,
  input  logic [31:0] in_first,
  input  logic [31:0] in_second,
  input  logic        in_last,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_dist,
  output logic        out_sat
);

  logic [1:0] metric_r;

  // stage one: products and difference
  logic signed [ELEMENT_WIDTH-1:0] xn, yn;
  logic signed [VAL_W-1:0]         xe, ye;
  logic signed [VAL_W:0]           diff;
  logic [VAL_W-1:0]                ad;
  logic                            take;
  logic [1:0]                      mcode;

  logic        s1_valid_r, s1_last_r;
  logic [1:0]  s1_metric_r;
  logic [31:0] s1_ad_r;
  logic [63:0] s1_sq_r, s1_xy_r, s1_xx_r, s1_yy_r;

  assign xn    = in_first[ELEMENT_WIDTH-1:0];
  assign yn    = in_second[ELEMENT_WIDTH-1:0];
  assign xe    = VAL_W'(xn);
  assign ye    = VAL_W'(yn);
  assign diff  = (VAL_W+1)'(xe) - (VAL_W+1)'(ye);
  assign ad    = diff[VAL_W] ? VAL_W'(-diff) : diff[VAL_W-1:0];
  assign take  = in_valid && cmd.accept_ok;
  assign mcode = (metric_r == METRIC_MANHATTAN || metric_r == METRIC_COSINE) ?
                 metric_r : METRIC_EUCLID;
  assign in_ready = cmd.accept_ok;

  // stage two: saturating accumulators
  logic [63:0] acc_r, n1_r, n2_r;
  logic        ovf_r;
  logic [1:0]  fin_metric_r;
  logic [64:0] su_add, n1_add, n2_add;
  logic [63:0] ss_add, acc_in;
  logic        ss_ovf;

  assign acc_in = (s1_metric_r == METRIC_MANHATTAN) ? {32'd0, s1_ad_r} : s1_sq_r;
  assign su_add = {1'b0, acc_r} + {1'b0, acc_in};
  assign n1_add = {1'b0, n1_r} + {1'b0, s1_xx_r};
  assign n2_add = {1'b0, n2_r} + {1'b0, s1_yy_r};
  assign ss_add = acc_r + s1_xy_r;
  assign ss_ovf = (acc_r[63] == s1_xy_r[63]) && (ss_add[63] != acc_r[63]);

  // shared 32x32 multiplier for the cosine finish
  logic         neg;
  logic [63:0]  mag, op_a, op_b;
  logic [31:0]  ha, hb;
  logic [63:0]  prod_r;
  logic [1:0]   shift_r;
  logic         tag_r, pv_r;
  logic [127:0] d_r, p_r, addend;

  assign neg    = acc_r[63];
  assign mag    = neg ? (~acc_r + 64'd1) : acc_r;
  assign op_a   = cmd.mul_step[2] ? n1_r : mag;
  assign op_b   = cmd.mul_step[2] ? n2_r : mag;
  assign ha     = cmd.mul_step[0] ? op_a[63:32] : op_a[31:0];
  assign hb     = cmd.mul_step[1] ? op_b[63:32] : op_b[31:0];
  assign addend = {64'd0, prod_r} << {shift_r, 5'd0};

  // restoring divider, one quotient bit a cycle
  logic [128:0] rem_r, rem2;
  logic [31:0]  quot_r, quot_nxt;
  logic         div_ge;

  assign rem2     = {rem_r[127:0], 1'b0};
  assign div_ge   = rem2 >= {1'b0, p_r};
  assign quot_nxt = {quot_r[30:0], div_ge};

  // square root, one result bit a cycle
  logic [63:0] sq_x_r, sq_res_r, sq_bit_r, sq_sum;
  logic        sq_ge;

  assign sq_sum = sq_res_r + sq_bit_r;
  assign sq_ge  = sq_x_r >= sq_sum;

  // result selection
  logic [31:0] res_dist;
  logic        rsat;
  logic [16:0] q;

  always_comb begin
    q    = sts.d_ge_p ? 17'h10000 : sq_res_r[16:0];
    rsat = ovf_r;
    case (fin_metric_r)
      METRIC_MANHATTAN: begin
        if (acc_r[63:32] != 32'd0) begin
          res_dist = 32'hFFFF_FFFF;
          rsat     = 1'b1;
        end else begin
          res_dist = acc_r[31:0];
        end
      end
      METRIC_COSINE: begin
        if (sts.zero_norm) res_dist = ONE_Q16;
        else if (neg)      res_dist = ONE_Q16 + {15'd0, q};
        else               res_dist = ONE_Q16 - {15'd0, q};
      end
      default: res_dist = sq_res_r[31:0];
    endcase
  end

  logic        out_valid_r, out_sat_r;
  logic [31:0] out_dist_r;

  assign out_valid = out_valid_r;
  assign out_dist  = out_dist_r;
  assign out_sat   = out_sat_r;

  assign sts.last_pending = s1_valid_r && s1_last_r;
  assign sts.fin_metric   = fin_metric_r;
  assign sts.zero_norm    = (n1_r == 64'd0) || (n2_r == 64'd0);
  assign sts.d_ge_p       = d_r >= p_r;
  assign sts.out_free     = !out_valid_r || out_ready;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      metric_r    <= METRIC_EUCLID;
      s1_valid_r  <= 1'b0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      n1_r        <= '0;
      n2_r        <= '0;
      ovf_r       <= 1'b0;
    end else begin
      if (cfg_we) metric_r <= cfg_data;
      s1_valid_r <= take;
      pv_r       <= cmd.mul_issue;
      if (cmd.load_out)   out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cmd.load_out) begin
        acc_r <= '0;
        n1_r  <= '0;
        n2_r  <= '0;
        ovf_r <= 1'b0;
      end else if (s1_valid_r) begin
        case (s1_metric_r)
          METRIC_COSINE: begin
            acc_r <= ss_ovf ? (acc_r[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : ss_add;
            n1_r  <= n1_add[64] ? '1 : n1_add[63:0];
            n2_r  <= n2_add[64] ? '1 : n2_add[63:0];
            if (ss_ovf || n1_add[64] || n2_add[64]) ovf_r <= 1'b1;
          end
          default: begin
            acc_r <= su_add[64] ? '1 : su_add[63:0];
            if (su_add[64]) ovf_r <= 1'b1;
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (take) begin
      s1_last_r   <= in_last;
      s1_metric_r <= mcode;
      s1_ad_r     <= ad;
      s1_sq_r     <= ad * ad;
      s1_xy_r     <= 64'(xe * ye);
      s1_xx_r     <= 64'(xe * xe);
      s1_yy_r     <= 64'(ye * ye);
    end
    if (s1_valid_r && s1_last_r) fin_metric_r <= s1_metric_r;

    if (cmd.mul_issue) begin
      prod_r  <= ha * hb;
      shift_r <= 2'({1'b0, cmd.mul_step[0]} + {1'b0, cmd.mul_step[1]});
      tag_r   <= cmd.mul_step[2];
    end
    if (cmd.mul_issue && cmd.mul_step == 3'd0) begin
      d_r <= '0;
      p_r <= '0;
    end else if (pv_r) begin
      if (tag_r) p_r <= p_r + addend;
      else       d_r <= d_r + addend;
    end

    if (cmd.div_init) begin
      rem_r  <= {1'b0, d_r};
      quot_r <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= div_ge ? (rem2 - {1'b0, p_r}) : rem2;
      quot_r <= quot_nxt;
    end

    if (cmd.sq_load_sum || cmd.sq_load_quot) begin
      sq_x_r   <= cmd.sq_load_sum ? acc_r : {32'd0, quot_nxt};
      sq_res_r <= '0;
      sq_bit_r <= 64'h4000_0000_0000_0000;
    end else if (cmd.sq_step) begin
      if (sq_ge) begin
        sq_x_r   <= sq_x_r - sq_sum;
        sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
      end else begin
        sq_res_r <= sq_res_r >> 1;
      end
      sq_bit_r <= sq_bit_r >> 2;
    end

    if (cmd.load_out) begin
      out_dist_r <= res_dist;
      out_sat_r  <= rsat;
    end
  end

  `VDE_ASSERT_NOW(a_load_free, cmd.load_out, !out_valid_r || out_ready, "result register overwritten")
  `VDE_ASSERT_NEXT(a_clear, cmd.load_out, acc_r == 64'd0 && !ovf_r, "accumulators not cleared")
  `VDE_ASSERT_NOW(a_rem_bound, cmd.div_step, rem_r < {1'b0, p_r}, "divider remainder out of range")

endmodule

### design/vector_distance_engine_core.sv
// finish: manhattan goes straight out, euclidean via root, cosine via multiply,
// divide, root (none on a zero norm; no divide or root if |dot| >= norm product)
// throughput: one element word per cycle within a vector; the finish of a
// vector (32-step root, 32-step divide, 8-step shared multiplier) holds off input
// reset: synchronous active-low rst_n clears accumulators, metric and valids
module vector_distance_engine_core import vde_pkg::*; #(
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // metric register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,
  // element pair stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // first_value[31:0], second_value[63:32]
  input  logic        in_tlast,   // last_element
  // distance stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // distance[31:0]
  output logic        out_tuser   // saturated
);

  vde_cmd_t cmd;
  vde_sts_t sts;

  // metric writes are always taken; the user must write only while idle, not enforced here
  assign cfg_ready = 1'b1;

  // sequencer for the end-of-vector work
  vde_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  // accumulators, shared arithmetic units and the output register
  vde_dp #(
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_data  (cfg_data),
    .cfg_we    (cfg_valid),
    .in_valid  (in_tvalid),
    .in_first  (in_tdata[31:0]),
    .in_second (in_tdata[63:32]),
    .in_last   (in_tlast),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_dist  (out_tdata),
    .out_sat   (out_tuser)
  );

endmodule
